// ===== hdl/assert_macros.svh =====
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AAWS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define AAWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/aaws_pkg.sv =====
// Types, constants and reduction trees of the ASAP/ALAP wire scheduler.
`timescale 1ns / 1ps
`default_nettype none

package aaws_pkg;

  localparam int TIME_W     = 7;
  localparam int MASK_W     = 16;
  localparam int WIRE_SLOTS = 16;

  typedef logic [TIME_W-1:0]                  time_t;
  typedef logic [MASK_W-1:0]                  mask_t;
  typedef logic [WIRE_SLOTS-1:0][TIME_W-1:0] wire_vec_t;

  // Maximum of all wire slots as a four-level tree.
  function automatic time_t max_tree(input wire_vec_t v);
    time_t l1 [8];
    time_t l2 [4];
    time_t l3 [2];
    for (int i = 0; i < 8; i++) l1[i] = (v[2*i] > v[2*i+1]) ? v[2*i] : v[2*i+1];
    for (int i = 0; i < 4; i++) l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    for (int i = 0; i < 2; i++) l3[i] = (l2[2*i] > l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    return (l3[0] > l3[1]) ? l3[0] : l3[1];
  endfunction

  // Minimum of all wire slots as a four-level tree.
  function automatic time_t min_tree(input wire_vec_t v);
    time_t l1 [8];
    time_t l2 [4];
    time_t l3 [2];
    for (int i = 0; i < 8; i++) l1[i] = (v[2*i] < v[2*i+1]) ? v[2*i] : v[2*i+1];
    for (int i = 0; i < 4; i++) l2[i] = (l1[2*i] < l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    for (int i = 0; i < 2; i++) l3[i] = (l2[2*i] < l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    return (l3[0] < l3[1]) ? l3[0] : l3[1];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/aaws_op_if.sv =====
// Operation request channel: barrier flag, wire mask and end-of-run mark.
`timescale 1ns / 1ps
`default_nettype none

interface aaws_op_if;
  logic            valid;
  logic            ready;
  logic            is_barrier;
  aaws_pkg::mask_t wire_mask;
  logic            last;

  modport source (output valid, is_barrier, wire_mask, last, input ready);
  modport sink   (input valid, is_barrier, wire_mask, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/aaws_slot_if.sv =====
// Slot result channel: start slot, end-of-run mark and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

interface aaws_slot_if;
  logic            valid;
  logic            ready;
  aaws_pkg::time_t slot_time;
  logic            last_result;
  logic            overflow;

  modport source (output valid, slot_time, last_result, overflow, input ready);
  modport sink   (input valid, slot_time, last_result, overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/aaws_cfg_if.sv =====
// Configuration write channel carrying the scheduling mode.
`timescale 1ns / 1ps
`default_nettype none

interface aaws_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/aaws_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module aaws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/asap_alap_wire_scheduler.sv =====
// Top level of the ASAP/ALAP wire scheduler.
//
// Usage:
//   op_in   - operation requests (is_barrier, wire_mask, last). One request is
//             taken per cycle while the block collects a run. Up to MAX_OPS
//             operations are stored; further ones are dropped and flagged.
//   slot_out - one result per stored operation, in input order, with
//             last_result on the final one and overflow on every result of a
//             run in which requests were dropped.
//   cfg     - mode register (0 ASAP, 1 ALAP), always ready, read at the end of
//             the forward pass and as each result is loaded.
// Sequence of a run:
//   the request marked last starts a forward pass; ALAP mode adds a depth step
//   and a reverse pass. Results then leave one at a time, the next one loaded
//   only after the one before is taken. op_in.ready stays low from the last request
//   until the final result is taken.
// Reset clears the mode, the run counters and the wire ready times. A stalled
// receiver holds the output register and the emission pointer in place.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asap_alap_wire_scheduler #(
  parameter int NUM_WIRES = 16,
  parameter int MAX_OPS   = 64
) (
  input  logic          clk,
  input  logic          rst,
  aaws_op_if.sink       op_in,
  aaws_slot_if.source   slot_out,
  aaws_cfg_if.sink      cfg
);

  localparam int TW  = aaws_pkg::TIME_W;
  localparam int MW  = aaws_pkg::MASK_W;
  localparam int WS  = aaws_pkg::WIRE_SLOTS;
  localparam int NW  = (NUM_WIRES < WS) ? NUM_WIRES : WS;
  localparam int AW  = $clog2(MAX_OPS);
  localparam int CW  = $clog2(MAX_OPS + 1);
  localparam int OPW = MW + 1;
  localparam int TMW = 2 * TW;

  typedef enum logic [2:0] {
    S_LOAD, S_FWD, S_DEPTH, S_REV, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  state_t          state;
  logic            mode;
  logic [CW-1:0]   op_count;
  logic            overflow_seen;
  logic [CW-1:0]   iptr;
  logic            pv;
  logic [AW-1:0]   paddr;
  logic [AW-1:0]   eptr;
  aaws_pkg::time_t depth;
  logic            out_valid;
  aaws_pkg::time_t out_time;
  logic            out_last;
  logic            out_ovf;

  logic            in_acc;
  logic            has_room;
  logic [CW-1:0]   count_dec;
  logic [CW-1:0]   iptr_dec;
  logic [AW-1:0]   last_idx;
  logic            issue_f;
  logic            issue_r;
  logic            emit_next;
  logic [AW-1:0]   rd_addr;
  logic            fwd_go;
  logic            rev_go;
  logic            clr_ready;

  logic [OPW-1:0]  op_rd_data;
  logic [TMW-1:0]  time_rd_data;
  logic            time_wr_en;
  logic [TMW-1:0]  time_wr_data;
  logic            q_barrier;
  aaws_pkg::mask_t q_mask;

  logic [WS-1:0]       used;
  aaws_pkg::wire_vec_t ready_vec;
  aaws_pkg::wire_vec_t ready_used;
  aaws_pkg::wire_vec_t dl_used;
  aaws_pkg::time_t     early_t;
  aaws_pkg::time_t     depth_val;
  aaws_pkg::time_t     dmin;
  aaws_pkg::time_t     rq_early;
  aaws_pkg::time_t     base;
  aaws_pkg::time_t     late_t;
  logic                any_used;
  logic                under;

  // Handshakes
  assign in_acc       = op_in.valid && op_in.ready;
  assign op_in.ready  = (state == S_LOAD);
  assign cfg.ready    = 1'b1;
  assign slot_out.valid       = out_valid;
  assign slot_out.slot_time   = out_time;
  assign slot_out.last_result = out_last;
  assign slot_out.overflow    = out_ovf;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      mode <= cfg.mode;
    end
  end

  // Derive pointers and read issue
  assign has_room  = (op_count < CW'(MAX_OPS));
  assign count_dec = CW'(op_count - 1'b1);
  assign iptr_dec  = CW'(iptr - 1'b1);
  assign last_idx  = count_dec[AW-1:0];
  assign issue_f   = (state == S_FWD) && (iptr < op_count);
  assign issue_r   = (state == S_REV) && (iptr != '0);
  assign emit_next = (state == S_EMIT_WAIT) && slot_out.ready && (eptr != last_idx);
  assign fwd_go    = (state == S_FWD) && pv;
  assign rev_go    = (state == S_REV) && pv;
  assign clr_ready = (state == S_EMIT_WAIT) && slot_out.ready && (eptr == last_idx);

  always_comb begin
    unique case (state)
      S_FWD:       rd_addr = iptr[AW-1:0];
      S_REV:       rd_addr = iptr_dec[AW-1:0];
      S_EMIT_RD:   rd_addr = eptr;
      S_EMIT_WAIT: rd_addr = AW'(eptr + 1'b1);
      default:     rd_addr = '0;
    endcase
  end

  // Operation store: barrier flag over wire mask
  aaws_ram #(.WIDTH(OPW), .DEPTH(MAX_OPS)) u_op_ram (
    .clk     (clk),
    .wr_en   (in_acc && has_room),
    .wr_addr (op_count[AW-1:0]),
    .wr_data ({op_in.is_barrier, op_in.wire_mask}),
    .rd_en   (issue_f || issue_r),
    .rd_addr (rd_addr),
    .rd_data (op_rd_data)
  );

  assign q_barrier = op_rd_data[MW];
  assign q_mask    = op_rd_data[MW-1:0];

  // Time store: early slot over late slot
  assign time_wr_en   = fwd_go || rev_go;
  assign time_wr_data = fwd_go ? {early_t, early_t} : {rq_early, late_t};

  aaws_ram #(.WIDTH(TMW), .DEPTH(MAX_OPS)) u_time_ram (
    .clk     (clk),
    .wr_en   (time_wr_en),
    .wr_addr (paddr),
    .wr_data (time_wr_data),
    .rd_en   (issue_r || (state == S_EMIT_RD) || emit_next),
    .rd_addr (rd_addr),
    .rd_data (time_rd_data)
  );

  assign rq_early = time_rd_data[TMW-1:TW];

  // Wire lanes: ready time and deadline per wire
  for (genvar w = 0; w < WS; w++) begin : g_wire
    if (w < NW) begin : g_on
      aaws_pkg::time_t ready_q;
      aaws_pkg::time_t dl_q;

      assign used[w]       = q_mask[w];
      assign ready_vec[w]  = ready_q;
      assign ready_used[w] = q_mask[w] ? ready_q : '0;
      assign dl_used[w]    = q_mask[w] ? dl_q : '1;

      // Advance ready time on the forward pass, drop it at run end
      always_ff @(posedge clk) begin
        if (rst || clr_ready) begin
          ready_q <= '0;
        end else if (fwd_go && q_mask[w]) begin
          ready_q <= q_barrier ? early_t : TW'(early_t + 1'b1);
        end
      end

      // Load deadline from the depth, then pull it back on the reverse pass
      always_ff @(posedge clk) begin
        if (state == S_DEPTH) begin
          dl_q <= depth_val;
        end else if (rev_go && q_mask[w]) begin
          dl_q <= late_t;
        end
      end
    end else begin : g_off
      assign used[w]       = 1'b0;
      assign ready_vec[w]  = '0;
      assign ready_used[w] = '0;
      assign dl_used[w]    = '1;
    end
  end

  // Forward and reverse slot arithmetic
  assign early_t   = aaws_pkg::max_tree(ready_used);
  assign depth_val = aaws_pkg::max_tree(ready_vec);
  assign dmin      = aaws_pkg::min_tree(dl_used);
  assign any_used  = |used;
  assign under     = any_used && (dmin == '0);
  assign base      = any_used ? TW'(dmin - 1'b1) : depth;

  always_comb begin
    if (q_barrier) begin
      late_t = any_used ? dmin : depth;
    end else if (under || (base < rq_early)) begin
      late_t = rq_early;
    end else begin
      late_t = base;
    end
  end

  // Sequencer: load, forward pass, depth and reverse pass (ALAP only), emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      op_count      <= '0;
      overflow_seen <= 1'b0;
      iptr          <= '0;
      pv            <= 1'b0;
      eptr          <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              op_count <= CW'(op_count + 1'b1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (op_in.last) begin
              state <= S_FWD;
              iptr  <= '0;
              pv    <= 1'b0;
            end
          end
        end
        S_FWD: begin
          // No read is issued once the last stored operation is in flight
          pv    <= issue_f;
          paddr <= rd_addr;
          if (issue_f) iptr <= CW'(iptr + 1'b1);
          if (pv && (paddr == last_idx)) begin
            state <= mode ? S_DEPTH : S_EMIT_RD;
            eptr  <= '0;
          end
        end
        S_DEPTH: begin
          depth <= depth_val;
          iptr  <= op_count;
          pv    <= 1'b0;
          state <= S_REV;
        end
        S_REV: begin
          // No read is issued once entry zero is in flight
          pv    <= issue_r;
          paddr <= rd_addr;
          if (issue_r) iptr <= iptr_dec;
          if (pv && (paddr == '0)) begin
            state <= S_EMIT_RD;
            eptr  <= '0;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_time  <= mode ? time_rd_data[TW-1:0] : rq_early;
          out_last  <= (eptr == last_idx);
          out_ovf   <= overflow_seen;
          out_valid <= 1'b1;
          state     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (slot_out.ready) begin
            out_valid <= 1'b0;
            if (eptr == last_idx) begin
              state         <= S_LOAD;
              op_count      <= '0;
              overflow_seen <= 1'b0;
            end else begin
              eptr  <= AW'(eptr + 1'b1);
              state <= S_EMIT_LD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Checks
  `AAWS_ASSERT(a_no_load_while_emit, clk, rst, !(op_in.ready && slot_out.valid), "request taken while a result is pending")
  `AAWS_ASSERT(a_count_bound, clk, rst, op_count <= CW'(MAX_OPS), "operation count beyond capacity")
  `AAWS_ASSERT(a_run_end, clk, rst, slot_out.valid && slot_out.ready && slot_out.last_result |=> op_in.ready && (op_count == '0), "run state not cleared after final result")

endmodule

`default_nettype wire

// ===== sim/asap_alap_wire_scheduler_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the wire scheduler: watches all channels, predicts slots, compares them.
module asap_alap_wire_scheduler_checker #(
  parameter int NUM_WIRES = 16,
  parameter int MAX_OPS   = 64
) (
  input  logic  clk,
  input  logic  rst,
  aaws_op_if    op_in,
  aaws_slot_if  slot_out,
  aaws_cfg_if   cfg,
  output int    fails,
  output int    pending
);
  import aaws_pkg::*;

  // Mask bits past the wire count carry no wire.
  localparam int WIRES_USED = (NUM_WIRES < MASK_W) ? NUM_WIRES : MASK_W;

  typedef struct packed {
    time_t slot_time;
    logic  last_result;
    logic  overflow;
  } slot_result_t;

  slot_result_t slot_expect_q[$];
  mask_t        op_mask [MAX_OPS];
  logic         op_barrier [MAX_OPS];
  int           op_cnt;
  logic         dropped;
  logic         alap_sel;
  int           fail_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_cnt++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Schedule the stored run and queue one slot per stored operation.
  function automatic void schedule_run(input logic alap);
    int           ready_t [MASK_W];
    int           dead_t [MASK_W];
    int           early_t [MAX_OPS];
    int           late_t [MAX_OPS];
    int           t;
    int           depth;
    slot_result_t r;
    for (int w = 0; w < MASK_W; w++) ready_t[w] = 0;
    // Forward pass: start at the latest wire, then push the wires on.
    for (int i = 0; i < op_cnt; i++) begin
      t = 0;
      for (int w = 0; w < WIRES_USED; w++)
        if (op_mask[i][w] && ready_t[w] > t) t = ready_t[w];
      early_t[i] = t;
      for (int w = 0; w < WIRES_USED; w++)
        if (op_mask[i][w]) ready_t[w] = op_barrier[i] ? t : t + 1;
    end
    // Reverse pass from the total depth; a non-barrier start is never earlier than the forward start.
    if (alap) begin
      depth = 0;
      for (int w = 0; w < WIRES_USED; w++)
        if (ready_t[w] > depth) depth = ready_t[w];
      for (int w = 0; w < MASK_W; w++) dead_t[w] = depth;
      for (int i = op_cnt - 1; i >= 0; i--) begin
        t = depth;
        if (op_barrier[i]) begin
          for (int w = 0; w < WIRES_USED; w++)
            if (op_mask[i][w] && dead_t[w] < t) t = dead_t[w];
        end else begin
          for (int w = 0; w < WIRES_USED; w++)
            if (op_mask[i][w] && dead_t[w] - 1 < t) t = dead_t[w] - 1;
          if (t < early_t[i]) t = early_t[i];
        end
        late_t[i] = t;
        for (int w = 0; w < WIRES_USED; w++)
          if (op_mask[i][w]) dead_t[w] = t;
      end
    end
    for (int i = 0; i < op_cnt; i++) begin
      r.slot_time   = time_t'(alap ? late_t[i] : early_t[i]);
      r.last_result = (i == op_cnt - 1);
      r.overflow    = dropped;
      slot_expect_q = {slot_expect_q, r};
    end
  endfunction

  // Track requests and results on every rising edge.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      alap_sel = 1'b0;
      op_cnt   = 0;
      dropped  = 1'b0;
      slot_expect_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) alap_sel = cfg.mode;
      // Store the request, or drop it once the run is full.
      if (op_in.valid && op_in.ready) begin
        if (op_cnt < MAX_OPS) begin
          op_mask[op_cnt]    = op_in.wire_mask;
          op_barrier[op_cnt] = op_in.is_barrier;
          op_cnt++;
        end else begin
          dropped = 1'b1;
        end
        if (op_in.last) begin
          schedule_run(alap_sel);
          op_cnt  = 0;
          dropped = 1'b0;
        end
      end
      // Compare each result with the oldest expected slot.
      if (slot_out.valid && slot_out.ready) begin
        if (slot_expect_q.size() == 0) begin
          report_mismatch("unexpected slot_time", 32'(slot_out.slot_time), 0);
        end else begin
          want = slot_expect_q.pop_front();
          if (slot_out.slot_time !== want.slot_time)
            report_mismatch("slot_time", 32'(slot_out.slot_time), 32'(want.slot_time));
          if (slot_out.last_result !== want.last_result)
            report_mismatch("last_result", 32'(slot_out.last_result),
                            32'(want.last_result));
          if (slot_out.overflow !== want.overflow)
            report_mismatch("overflow", 32'(slot_out.overflow), 32'(want.overflow));
        end
      end
    end
    pending <= slot_expect_q.size();
    fails   <= fail_cnt;
  end

endmodule

// ===== sim/asap_alap_wire_scheduler_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the wire scheduler: stimulus, receiver stalls and verdict.
module asap_alap_wire_scheduler_test;
  import aaws_pkg::*;

  localparam int   NUM_WIRES    = 16;
  localparam int   MAX_OPS      = 64;
  localparam logic MODE_ASAP    = 1'b0;
  localparam logic MODE_ALAP    = 1'b1;
  localparam int   RESET_CYCLES = 12;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   END_CYCLES   = 40;
  localparam int   RANDOM_ITEMS = 152;
  localparam int   CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   fails;
  int   pending;
  int   burst_left = 0;
  int   stall_style = 0;
  int   stall_left = 0;
  int   stall_phase = 0;
  int   run_ops = 0;
  int   items_sent = 0;
  int   runs_sent = 0;
  int   alap_runs = 0;
  int   overflow_runs = 0;
  int   barrier_ops = 0;
  logic cur_mode = MODE_ASAP;

  aaws_op_if   op_if ();
  aaws_slot_if slot_if ();
  aaws_cfg_if  cfg_if ();

  asap_alap_wire_scheduler #(
    .NUM_WIRES (NUM_WIRES),
    .MAX_OPS   (MAX_OPS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .op_in    (op_if),
    .slot_out (slot_if),
    .cfg      (cfg_if)
  );

  asap_alap_wire_scheduler_checker #(
    .NUM_WIRES (NUM_WIRES),
    .MAX_OPS   (MAX_OPS)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .op_in    (op_if),
    .slot_out (slot_if),
    .cfg      (cfg_if),
    .fails    (fails),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result channel, switching at random between four patterns.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 90);
    end
    stall_left--;
    stall_phase++;
    case (stall_style)
      0: slot_if.ready <= 1'b1;
      1: slot_if.ready <= 1'($urandom_range(0, 1));
      2: slot_if.ready <= ($urandom_range(0, 3) == 0);
      default: slot_if.ready <= ((stall_phase % 9) >= 5);
    endcase
  end

  // Send one operation request, in bursts with random gaps between them.
  task automatic send_op(input logic barrier, input mask_t mask, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 10);
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    op_if.valid      <= 1'b1;
    op_if.is_barrier <= barrier;
    op_if.wire_mask  <= mask;
    op_if.last       <= last;
    do @(posedge clk); while (!op_if.ready);
    items_sent++;
    run_ops++;
    if (barrier) barrier_ops++;
    // Drop valid after the end of a run so no request repeats.
    if (last) begin
      op_if.valid <= 1'b0;
      runs_sent++;
      if (cur_mode == MODE_ALAP) alap_runs++;
      if (run_ops > MAX_OPS) overflow_runs++;
      run_ops = 0;
      @(posedge clk);
    end
  endtask

  // Hold off until every expected slot has come back.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_mode = mode;
    @(posedge clk);
  endtask

  initial begin
    int    run_len;
    int    run_idx;
    int    random_end;
    logic  barrier;
    mask_t mask;
    rst              <= 1'b1;
    op_if.valid      <= 1'b0;
    op_if.is_barrier <= 1'b0;
    op_if.wire_mask  <= '0;
    op_if.last       <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.mode      <= MODE_ASAP;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(MODE_ASAP);

    // Early mode: lone empty mask, full and edge wires, barriers incl. an empty one.
    send_op(1'b0, 16'h0000, 1'b1);
    send_op(1'b0, 16'hFFFF, 1'b0);
    send_op(1'b0, 16'h0001, 1'b0);
    send_op(1'b1, 16'hFFFF, 1'b0);
    send_op(1'b0, 16'h8000, 1'b0);
    send_op(1'b0, 16'h0003, 1'b0);
    send_op(1'b1, 16'h0000, 1'b1);
    wait_drained();
    write_mode(MODE_ALAP);

    // Late mode: chain on one wire, clamped starts, barrier, empty masks.
    send_op(1'b0, 16'h0001, 1'b0);
    send_op(1'b0, 16'h0001, 1'b0);
    send_op(1'b0, 16'h0002, 1'b0);
    send_op(1'b1, 16'h0003, 1'b0);
    send_op(1'b0, 16'h0000, 1'b0);
    send_op(1'b0, 16'hFFFF, 1'b0);
    send_op(1'b0, 16'hAAAA, 1'b0);
    send_op(1'b0, 16'h5555, 1'b1);
    send_op(1'b1, 16'h0000, 1'b1);
    send_op(1'b1, 16'hFFFF, 1'b0);
    send_op(1'b0, 16'h7FFE, 1'b1);

    // Random runs, mostly short; the first overfills the store and drops its last two requests.
    random_end = items_sent + RANDOM_ITEMS;
    run_idx = 0;
    while (items_sent < random_end) begin
      if (run_idx == 0 || $urandom_range(0, 3) == 0) begin
        wait_drained();
        write_mode(1'($urandom_range(0, 1)));
      end
      if (run_idx == 0) run_len = MAX_OPS + 2;
      else if ($urandom_range(0, 19) == 0) run_len = $urandom_range(20, MAX_OPS + 3);
      else run_len = $urandom_range(1, 12);
      // Keep the item total near its target.
      if (run_len > random_end - items_sent) run_len = random_end - items_sent;
      for (int i = 0; i < run_len; i++) begin
        barrier = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
          0: mask = mask_t'($urandom());
          1: mask = mask_t'(1) << $urandom_range(0, MASK_W - 1);
          2: mask = (mask_t'(1) << $urandom_range(0, MASK_W - 1)) |
                    (mask_t'(1) << $urandom_range(0, MASK_W - 1));
          3: mask = '0;
          4: mask = '1;
          default: mask = mask_t'($urandom_range(0, 15));
        endcase
        send_op(barrier, mask, i == run_len - 1);
      end
      run_idx++;
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d requests in %0d runs: %0d late-mode runs, %0d over capacity",
             items_sent, runs_sent, alap_runs, overflow_runs);
    $display("%0d barrier requests, %0d cycles, %0d mismatches", barrier_ops, cycles, fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
